>>> rtl/core/tbc_pkg.sv
// shared types and constants for the barycentric weight block
`timescale 1ns / 1ps
package tbc_pkg;

  // field formats
  localparam int COORD_WIDTH      = 24;
  localparam int WEIGHT_FRAC_BITS = 20;
  localparam int OUT_WIDTH        = 24;

  // datapath widths
  localparam int SV_W    = COORD_WIDTH + 1;          // vertex minus query point
  localparam int EF_W    = COORD_WIDTH + 2;          // triangle edge
  localparam int NORM_W  = 2 * EF_W + 1;             // normal component
  localparam int AREA_W  = 2 * SV_W + 1;             // sub-triangle cross component
  localparam int DOT_W   = 2 * NORM_W + 2;           // dot product of normal and cross
  localparam int SPLIT_W = (NORM_W + 1) / 2;         // low half of a split operand
  localparam int HI_W    = NORM_W - SPLIT_W;         // high half of a split operand
  localparam int PP_W    = 2 * (SPLIT_W + 1);        // partial product
  localparam int NUM_W   = DOT_W + WEIGHT_FRAC_BITS + 2;
  localparam int REM_W   = NUM_W + OUT_WIDTH;        // divider remainder

  // weight 1.0, clamped to the largest positive weight
  localparam logic [63:0] ONE_VAL = (WEIGHT_FRAC_BITS < OUT_WIDTH - 1) ?
      (64'd1 << WEIGHT_FRAC_BITS) : ((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
  localparam logic [OUT_WIDTH-1:0] WEIGHT_ONE = ONE_VAL[OUT_WIDTH-1:0];

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [OUT_WIDTH-1:0]   weight_t;
  typedef logic signed [NORM_W-1:0]      norm_t;
  typedef logic signed [AREA_W-1:0]      area_t;

  // input word
  typedef struct packed {
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_a_z;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_b_z;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
    coord_t vertex_c_z;
    coord_t query_x;
    coord_t query_y;
    coord_t query_z;
  } item_t;

  // result word
  typedef struct packed {
    weight_t weight_a;
    weight_t weight_b;
    weight_t weight_c;
    logic    degenerate;
  } result_t;

  // classified triangle handed from front to back
  typedef struct packed {
    norm_t [2:0]      normal;
    area_t [2:0][2:0] area;
    logic             degenerate;
  } plane_t;

endpackage

>>> rtl/core/tbc_queue.sv
// small first-word-fall-through queue
`timescale 1ns / 1ps
module tbc_queue #(
  parameter type word_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  word_t push_word,
  output logic  full,
  input  logic  pop,
  output word_t pop_word,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  word_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  // handshake
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    do_pop && !do_push |=> count == $past(count) - CNT_W'(1))
    else $error("queue count missed a pop");

endmodule

>>> rtl/core/tbc_front.sv
// front pipeline: takes a word, builds normal and sub-triangle crosses, flags zero area
`timescale 1ns / 1ps
module tbc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  tbc_pkg::item_t  item,
  output logic            plane_push,
  output tbc_pkg::plane_t plane,
  input  logic            plane_full
);

  import tbc_pkg::*;

  coord_t                   vtx [3][3];
  coord_t                   qry [3];
  logic [3:0]               stage_valid;
  logic                     adv;

  logic signed [SV_W-1:0]   s1_sv [3][3];
  logic signed [SV_W-1:0]   s2_sv [3][3];
  logic signed [EF_W-1:0]   s2_e [3];
  logic signed [EF_W-1:0]   s2_f [3];
  logic signed [2*EF_W-1:0] s3_pn [3][2];
  logic signed [2*SV_W-1:0] s3_pc [3][3][2];
  norm_t                    norm_next [3];
  area_t                    area_next [3][3];
  norm_t                    s4_norm [3];
  area_t                    s4_area [3][3];
  logic                     s4_deg;

  // unpack the word
  always_comb begin
    vtx[0][0] = item.vertex_a_x;
    vtx[0][1] = item.vertex_a_y;
    vtx[0][2] = item.vertex_a_z;
    vtx[1][0] = item.vertex_b_x;
    vtx[1][1] = item.vertex_b_y;
    vtx[1][2] = item.vertex_b_z;
    vtx[2][0] = item.vertex_c_x;
    vtx[2][1] = item.vertex_c_y;
    vtx[2][2] = item.vertex_c_z;
    qry[0]    = item.query_x;
    qry[1]    = item.query_y;
    qry[2]    = item.query_z;
  end

  // pipeline advances unless the last stage is stuck on a full queue
  assign adv        = !stage_valid[3] || !plane_full;
  assign full       = !adv;
  assign plane_push = stage_valid[3] && !plane_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (adv) begin
      stage_valid <= {stage_valid[2:0], push};
    end
  end

  // stage 1: move query point to the origin
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int v = 0; v < 3; v++) begin
        for (int k = 0; k < 3; k++) begin
          s1_sv[v][k] <= SV_W'(vtx[v][k]) - SV_W'(qry[k]);
        end
      end
    end
  end

  // stage 2: edges from the first vertex
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sv <= s1_sv;
      for (int k = 0; k < 3; k++) begin
        s2_e[k] <= EF_W'(s1_sv[1][k]) - EF_W'(s1_sv[0][k]);
        s2_f[k] <= EF_W'(s1_sv[2][k]) - EF_W'(s1_sv[0][k]);
      end
    end
  end

  // stage 3: cross product terms
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s3_pn[k][0] <= (2*EF_W)'(s2_e[(k+1)%3]) * (2*EF_W)'(s2_f[(k+2)%3]);
        s3_pn[k][1] <= (2*EF_W)'(s2_e[(k+2)%3]) * (2*EF_W)'(s2_f[(k+1)%3]);
      end
      for (int v = 0; v < 3; v++) begin
        for (int k = 0; k < 3; k++) begin
          s3_pc[v][k][0] <= (2*SV_W)'(s2_sv[(v+1)%3][(k+1)%3]) *
                            (2*SV_W)'(s2_sv[(v+2)%3][(k+2)%3]);
          s3_pc[v][k][1] <= (2*SV_W)'(s2_sv[(v+1)%3][(k+2)%3]) *
                            (2*SV_W)'(s2_sv[(v+2)%3][(k+1)%3]);
        end
      end
    end
  end

  // stage 4: finish crosses, zero normal means zero area
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      norm_next[k] = NORM_W'(s3_pn[k][0]) - NORM_W'(s3_pn[k][1]);
    end
    for (int v = 0; v < 3; v++) begin
      for (int k = 0; k < 3; k++) begin
        area_next[v][k] = AREA_W'(s3_pc[v][k][0]) - AREA_W'(s3_pc[v][k][1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_norm <= norm_next;
      s4_area <= area_next;
      s4_deg  <= (norm_next[0] == '0) && (norm_next[1] == '0) && (norm_next[2] == '0);
    end
  end

  // pack for the queue
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      plane.normal[k] = s4_norm[k];
      for (int v = 0; v < 3; v++) begin
        plane.area[v][k] = s4_area[v][k];
      end
    end
    plane.degenerate = s4_deg;
  end

endmodule

>>> rtl/core/tbc_back.sv
// back pipeline: dot products, then one quotient bit per stage, round and saturate
`timescale 1ns / 1ps
module tbc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             plane_empty,
  input  tbc_pkg::plane_t  plane,
  output logic             plane_pop,
  output logic             result_push,
  output tbc_pkg::result_t result,
  input  logic             result_full
);

  import tbc_pkg::*;

  localparam int NSTG = OUT_WIDTH + 6;

  // one divider stage for all three weights
  typedef struct packed {
    logic [2:0][REM_W-1:0]     rem;
    logic [2:0][OUT_WIDTH-1:0] quo;
    logic [2:0]                neg;
    logic [2:0]                ovf;
    logic [REM_W-1:0]          den;
    logic                      deg;
  } div_t;

  logic [NSTG-1:0]            vld;
  logic                       adv;

  logic signed [NORM_W-1:0]   op [4][3][2];
  logic signed [HI_W-1:0]     op_hi [4][3][2];
  logic signed [SPLIT_W:0]    op_lo [4][3][2];
  logic signed [PP_W-1:0]     b1_pp [4][3][4];
  logic                       b1_deg;
  logic signed [DOT_W-1:0]    b2_prod [4][3];
  logic                       b2_deg;
  logic signed [DOT_W-1:0]    b3_dot [4];
  logic                       b3_deg;
  logic [DOT_W-1:0]           mag [3];
  logic [REM_W-1:0]           b4_rem [3];
  logic [REM_W-1:0]           b4_den;
  logic [2:0]                 b4_neg;
  logic                       b4_deg;
  div_t                       dstg [OUT_WIDTH+1];
  logic [OUT_WIDTH-1:0]       lim [3];
  logic [OUT_WIDTH-1:0]       mag_sat [3];
  result_t                    res;

  // stall only when the finished word cannot leave
  assign adv         = !vld[NSTG-1] || !result_full;
  assign plane_pop   = !plane_empty && adv;
  assign result_push = vld[NSTG-1] && !result_full;
  assign result      = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], plane_pop};
    end
  end

  // operands: normal against itself, then against each sub-triangle cross
  always_comb begin
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 3; k++) begin
        op[m][k][0] = $signed(plane.normal[k]);
        if (m == 0) begin
          op[m][k][1] = $signed(plane.normal[k]);
        end else begin
          op[m][k][1] = NORM_W'($signed(plane.area[m-1][k]));
        end
        for (int o = 0; o < 2; o++) begin
          op_hi[m][k][o] = $signed(op[m][k][o][NORM_W-1:SPLIT_W]);
          op_lo[m][k][o] = $signed({1'b0, op[m][k][o][SPLIT_W-1:0]});
        end
      end
    end
  end

  // b1: split products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 4; m++) begin
        for (int k = 0; k < 3; k++) begin
          b1_pp[m][k][0] <= PP_W'(op_hi[m][k][0]) * PP_W'(op_hi[m][k][1]);
          b1_pp[m][k][1] <= PP_W'(op_hi[m][k][0]) * PP_W'(op_lo[m][k][1]);
          b1_pp[m][k][2] <= PP_W'(op_lo[m][k][0]) * PP_W'(op_hi[m][k][1]);
          b1_pp[m][k][3] <= PP_W'(op_lo[m][k][0]) * PP_W'(op_lo[m][k][1]);
        end
      end
      b1_deg <= plane.degenerate;
    end
  end

  // b2: recombine partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 4; m++) begin
        for (int k = 0; k < 3; k++) begin
          b2_prod[m][k] <= (DOT_W'(b1_pp[m][k][0]) <<< (2*SPLIT_W)) +
                           ((DOT_W'(b1_pp[m][k][1]) + DOT_W'(b1_pp[m][k][2])) <<< SPLIT_W) +
                           DOT_W'(b1_pp[m][k][3]);
        end
      end
      b2_deg <= b1_deg;
    end
  end

  // b3: dot products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 4; m++) begin
        b3_dot[m] <= b2_prod[m][0] + b2_prod[m][1] + b2_prod[m][2];
      end
      b3_deg <= b2_deg;
    end
  end

  // b4: sign and magnitude, scaled numerator with half divisor for rounding
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = b3_dot[l+1][DOT_W-1] ? DOT_W'(-b3_dot[l+1]) : DOT_W'(b3_dot[l+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        b4_rem[l] <= (REM_W'(mag[l]) << (WEIGHT_FRAC_BITS + 1)) +
                     REM_W'(unsigned'(b3_dot[0]));
        b4_neg[l] <= b3_dot[l+1][DOT_W-1];
      end
      b4_den <= REM_W'(unsigned'(b3_dot[0])) << 1;
      b4_deg <= b3_deg;
    end
  end

  // b5: quotient too large for the weight field
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        dstg[0].rem[l] <= b4_rem[l];
        dstg[0].ovf[l] <= b4_rem[l] >= (b4_den << OUT_WIDTH);
      end
      dstg[0].quo <= '0;
      dstg[0].neg <= b4_neg;
      dstg[0].den <= b4_den;
      dstg[0].deg <= b4_deg;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar s = 0; s < OUT_WIDTH; s++) begin : g_div
    localparam int SH = OUT_WIDTH - 1 - s;
    logic [REM_W-1:0] step_den;
    div_t             stage_next;

    assign step_den = dstg[s].den << SH;

    always_comb begin
      stage_next = dstg[s];
      for (int l = 0; l < 3; l++) begin
        if (dstg[s].rem[l] >= step_den) begin
          stage_next.rem[l]     = dstg[s].rem[l] - step_den;
          stage_next.quo[l][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dstg[s+1] <= stage_next;
      end
    end
  end

  // saturate, restore sign, zero-area fallback
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lim[l] = dstg[OUT_WIDTH].neg[l] ? {1'b1, {(OUT_WIDTH-1){1'b0}}} :
                                        {1'b0, {(OUT_WIDTH-1){1'b1}}};
      mag_sat[l] = (dstg[OUT_WIDTH].ovf[l] || (dstg[OUT_WIDTH].quo[l] > lim[l])) ?
                   lim[l] : dstg[OUT_WIDTH].quo[l];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dstg[OUT_WIDTH].deg) begin
        res.weight_a   <= WEIGHT_ONE;
        res.weight_b   <= '0;
        res.weight_c   <= '0;
        res.degenerate <= 1'b1;
      end else begin
        res.weight_a   <= dstg[OUT_WIDTH].neg[0] ? -mag_sat[0] : mag_sat[0];
        res.weight_b   <= dstg[OUT_WIDTH].neg[1] ? -mag_sat[1] : mag_sat[1];
        res.weight_c   <= dstg[OUT_WIDTH].neg[2] ? -mag_sat[2] : mag_sat[2];
        res.degenerate <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/triangle_barycentric_coords_top.sv
// Barycentric weights of a point against a triangle, Q12.12 in, saturating Q4.20 out.
// One word is taken per clock and one result word comes out per clock while
// no queue backs up. A word passes through the front stages, the middle queue,
// the back stages and the result queue. The back stages first split the wide
// multiplies and sum the dot products, then scale and range-check the numerator,
// then run the pipelined restoring divider (one quotient bit per stage, which
// sets the depth), and finally saturate, restore sign, zero-area fallback.
// A zero-area triangle yields weights 1,0,0 with degenerate set. The front and
// back halves are joined by a small queue and each stalls on its own; a result
// queue on the output lets new words enter while finished words wait.
`timescale 1ns / 1ps
module triangle_barycentric_coords_top #(
  parameter int FRONT_QUEUE_DEPTH  = 4,
  parameter int RESULT_QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  tbc_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output tbc_pkg::result_t result
);

  import tbc_pkg::*;

  logic    plane_push;
  plane_t  plane_in;
  logic    plane_full;
  logic    plane_pop;
  plane_t  plane_out;
  logic    plane_empty;
  logic    result_push;
  result_t result_in;
  logic    result_full;

  // front: shift, cross products, classify
  tbc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .plane_push (plane_push),
    .plane      (plane_in),
    .plane_full (plane_full)
  );

  // decoupling queue between the halves
  tbc_queue #(
    .word_t (plane_t),
    .DEPTH  (FRONT_QUEUE_DEPTH)
  ) u_plane_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (plane_push),
    .push_word (plane_in),
    .full      (plane_full),
    .pop       (plane_pop),
    .pop_word  (plane_out),
    .empty     (plane_empty)
  );

  // back: dot products and division
  tbc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .plane_empty (plane_empty),
    .plane       (plane_out),
    .plane_pop   (plane_pop),
    .result_push (result_push),
    .result      (result_in),
    .result_full (result_full)
  );

  // result queue
  tbc_queue #(
    .word_t (result_t),
    .DEPTH  (RESULT_QUEUE_DEPTH)
  ) u_result_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (result_push),
    .push_word (result_in),
    .full      (result_full),
    .pop       (pop),
    .pop_word  (result),
    .empty     (empty)
  );

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.degenerate |-> result.weight_b == '0 && result.weight_c == '0)
    else $error("zero-area word with nonzero b or c weight");

  a_degen_one: assert property (@(posedge clk) disable iff (rst)
    !empty && result.degenerate |-> result.weight_a == WEIGHT_ONE)
    else $error("zero-area word without unit a weight");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("block not idle after reset");

endmodule

>>> tb/tb_triangle_barycentric_coords_top.sv
// testbench for the barycentric weight block: queued stimulus, exact predictor, scoreboard
`timescale 1ns / 1ps
module tb_triangle_barycentric_coords_top;
  import tbc_pkg::*;

  localparam int LATENCY = 40;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  item_t item = '0;
  result_t result;

  item_t pending_words[$];
  result_t expected_weights[$];
  int error_count = 0;
  int checked_count = 0;
  int degenerate_count = 0;
  int sent_count = 0;
  int idle_cycles = 0;
  bit hold_for_drain = 1'b0;
  bit stimulus_done = 1'b0;

  triangle_barycentric_coords_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  always #5 clk = ~clk;

  // rounded, saturated num * 2^F / den; den > 0
  function automatic weight_t scaled_ratio(logic signed [255:0] num, logic signed [255:0] den);
    logic signed [255:0] mag, q;
    logic signed [255:0] lim;
    bit neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = ((mag <<< (WEIGHT_FRAC_BITS + 1)) + den) / (den <<< 1);
    lim = (256'sd1 <<< (OUT_WIDTH - 1)) - (neg ? 0 : 1);
    if (q > lim) q = lim;
    return neg ? weight_t'(-q) : weight_t'(q);
  endfunction

  // exact weights from the plane normal and the sub-triangle cross products
  function automatic result_t barycentric_weights(item_t w);
    logic signed [255:0] s[3][3];
    logic signed [255:0] e[3], f[3], n[3], c[3], nn, d;
    logic signed [255:0] raw[12];
    result_t r;
    int j, k;
    raw = '{w.vertex_a_x, w.vertex_a_y, w.vertex_a_z, w.vertex_b_x, w.vertex_b_y,
            w.vertex_b_z, w.vertex_c_x, w.vertex_c_y, w.vertex_c_z,
            w.query_x, w.query_y, w.query_z};
    for (int v = 0; v < 3; v++)
      for (k = 0; k < 3; k++) s[v][k] = raw[v * 3 + k] - raw[9 + k];
    for (k = 0; k < 3; k++) begin
      e[k] = s[1][k] - s[0][k];
      f[k] = s[2][k] - s[0][k];
    end
    n[0] = e[1] * f[2] - e[2] * f[1];
    n[1] = e[2] * f[0] - e[0] * f[2];
    n[2] = e[0] * f[1] - e[1] * f[0];
    nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    if (nn == 0) begin
      r.weight_a = WEIGHT_ONE;
      r.weight_b = '0;
      r.weight_c = '0;
      r.degenerate = 1'b1;
      return r;
    end
    for (int v = 0; v < 3; v++) begin
      j = (v + 1) % 3;
      k = (v + 2) % 3;
      c[0] = s[j][1] * s[k][2] - s[j][2] * s[k][1];
      c[1] = s[j][2] * s[k][0] - s[j][0] * s[k][2];
      c[2] = s[j][0] * s[k][1] - s[j][1] * s[k][0];
      d = n[0] * c[0] + n[1] * c[1] + n[2] * c[2];
      if (v == 0) r.weight_a = scaled_ratio(d, nn);
      else if (v == 1) r.weight_b = scaled_ratio(d, nn);
      else r.weight_c = scaled_ratio(d, nn);
    end
    r.degenerate = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, checked_count);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 8192)) - coord_t'(4096);
      2: return ($urandom_range(0, 1)) ? coord_t'(24'h7fffff) : coord_t'(24'h800000);
      default: return coord_t'($urandom_range(0, 255)) <<< $urandom_range(0, 16);
    endcase
  endfunction

  function automatic item_t rand_word();
    item_t w;
    int mode;
    mode = $urandom_range(0, 9);
    mode = (mode < 3) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
    w = {rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    // repeated vertices (c copies b) for the zero-area path
    if ($urandom_range(0, 9) == 0) begin
      w.vertex_c_x = w.vertex_b_x;
      w.vertex_c_y = w.vertex_b_y;
      w.vertex_c_z = w.vertex_b_z;
    end
    return w;
  endfunction

  // stimulus: directed corners, then random triangles
  initial begin
    item_t w;
    w = '0;
    pending_words = {pending_words, w};
    w = {24'h001000, 24'h0, 24'h0, 24'h0, 24'h001000, 24'h0, 24'h0, 24'h0, 24'h001000,
         24'h000555, 24'h000555, 24'h000555};
    pending_words = {pending_words, w};
    w = {24'h0, 24'h0, 24'h0, 24'h001000, 24'h0, 24'h0, 24'h0, 24'h001000, 24'h0,
         24'h7fffff, 24'h800000, 24'h7fffff};
    pending_words = {pending_words, w};
    w = {24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h800000, 24'h800000,
         24'h800000, 24'h7fffff, 24'h7fffff, 24'h0, 24'h0, 24'h0};
    pending_words = {pending_words, w};
    w = {24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000,
         24'h7fffff, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000};
    pending_words = {pending_words, w};
    w = '1;
    pending_words = {pending_words, w};
    // collinear points
    w = {24'h0, 24'h0, 24'h0, 24'h1, 24'h1, 24'h1, 24'h2, 24'h2, 24'h2, 24'h5, 24'h0, 24'h0};
    pending_words = {pending_words, w};
    // tiny triangle, far point: saturation both ways
    w = {24'h0, 24'h0, 24'h0, 24'h1, 24'h0, 24'h0, 24'h0, 24'h1, 24'h0,
         24'h7fffff, 24'h7fffff, 24'h0};
    pending_words = {pending_words, w};
    w.query_x = 24'h800000;
    pending_words = {pending_words, w};
    // x then y normal dominant, then a y-z tie
    w = {24'h0, 24'h0, 24'h0, 24'h0, 24'h2000, 24'h0, 24'h0, 24'h0, 24'h2000,
         24'h0, 24'h800, 24'h800};
    pending_words = {pending_words, w};
    w = {24'h0, 24'h0, 24'h0, 24'h2000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h2000,
         24'h800, 24'h0, 24'h800};
    pending_words = {pending_words, w};
    w = {24'h0, 24'h0, 24'h0, 24'h2000, 24'h0, 24'h0, 24'h0, 24'h2000, 24'h2000,
         24'h555, 24'h555, 24'h555};
    pending_words = {pending_words, w};
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_words = {pending_words, rand_word()};
  end

  // driver: bursts and gaps, one drain pause midway
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_weights = {expected_weights, barycentric_weights(item)};
        sent_count++;
        void'(pending_words.pop_front());
        if (sent_count == 600) hold_for_drain = 1'b1;
      end
      if (hold_for_drain && expected_weights.size() == 0 && !(push && !full))
        hold_for_drain = 1'b0;
      if (gap_left > 0) gap_left--;
      if (pending_words.size() == 0 || hold_for_drain || gap_left > 0) begin
        push <= 1'b0;
        if (pending_words.size() == 0) stimulus_done = 1'b1;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 2) != 0) gap_left = $urandom_range(0, 6);
        end
        if (gap_left > 0) begin
          push <= 1'b0;
        end else begin
          burst_left--;
          push <= 1'b1;
          item <= pending_words[0];
        end
      end
    end
  end

  // monitor: receiver stall pattern and result check
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_weights.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          result_t want;
          want = expected_weights.pop_front();
          if (result.weight_a !== want.weight_a)
            report_mismatch("weight_a", result.weight_a, want.weight_a);
          if (result.weight_b !== want.weight_b)
            report_mismatch("weight_b", result.weight_b, want.weight_b);
          if (result.weight_c !== want.weight_c)
            report_mismatch("weight_c", result.weight_c, want.weight_c);
          if (result.degenerate !== want.degenerate)
            report_mismatch("degenerate", result.degenerate, want.degenerate);
          if (want.degenerate) degenerate_count++;
        end
        checked_count++;
      end
      stall_phase = (stall_phase + 1) % 512;
      if (stall_phase < 150) pop <= 1'b1;
      else if (stall_phase < 300) pop <= (stall_phase % 3) != 0;
      else pop <= ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        wait (stimulus_done && expected_weights.size() == 0);
        repeat (LATENCY) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no progress, %0d results outstanding", expected_weights.size());
        error_count++;
      end
    join_any
    $display("sent %0d triangles, checked %0d weight words, %0d zero-area cases",
             sent_count, checked_count, degenerate_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
